// ===== design/gps_pkg.sv =====
// Package for the graph path search block: sizes, payload structs, codes.
// No dependencies; used by the top level and the testbench.
package gps_pkg;

   localparam int MaxNodes  = 64;
   localparam int NodeWidth = $clog2(MaxNodes);
   localparam int CountWidth = NodeWidth + 1;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_FIND = 1'b1;

   localparam logic [0:0] CSR_SEARCH_ORDER = 1'b0;
   localparam logic [0:0] CSR_NODE_COUNT   = 1'b1;

   typedef struct packed {
      logic                 operation;
      logic [5:0]           from_node;
      logic [5:0]           to_node;
      logic                 edge_present;
   } req_type;

   typedef struct packed {
      logic [5:0] path_node;
      logic       path_found;
      logic       last;
   } rsp_type;

endpackage

// ===== design/gps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gps_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/graph_path_search.sv =====
// Top level of the graph path search block.
// Depends on gps_pkg and gps_ram.
//
// Usage: configuration registers are written through csr_write_enable,
// csr_index and csr_write_data while the block is idle. Register 0 selects
// depth-first (0) or breadth-first (1) search; register 1 holds the node count.
// Input words arrive on req_valid/req_ready. An edge word writes one bit of the
// adjacency matrix in a read-modify-write (states EDGE, EDGEW), after which the
// next word can be taken. A find word searches from from_node to to_node and
// returns the path on rsp_valid/rsp_ready, one word per node, source first,
// with last set on the final word; if no path exists one word with path_found
// clear is returned. The block handles one item at a time.
// A search pops each node from the worklist (POP, POPW), reads its adjacency
// row (ROW) and scans every node index below the node count (the scan walks
// the adjacency row one bit a cycle), then walks the parent entries back to
// the source (WALK, WALKW), starts the path read (EMITW) and emits one word
// per path node (EMIT).
// After reset a clearing pass zeros every row of the adjacency memory, during
// which no word is accepted. A stalled receiver holds the output register; the
// next word waits until it is taken, but a new search can run meanwhile.
module graph_path_search (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gps_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gps_pkg::rsp_type      rsp_data,
   input  logic                  csr_write_enable,
   input  logic [0:0]            csr_index,
   input  logic [6:0]            csr_write_data
);

   localparam int NW = gps_pkg::NodeWidth;
   localparam int CW = gps_pkg::CountWidth;
   localparam int MN = gps_pkg::MaxNodes;

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_EDGE   = 4'd2;
   localparam logic [3:0] ST_POP    = 4'd3;
   localparam logic [3:0] ST_POPW   = 4'd4;
   localparam logic [3:0] ST_ROW    = 4'd5;
   localparam logic [3:0] ST_SCAN   = 4'd6;
   localparam logic [3:0] ST_WALK   = 4'd7;
   localparam logic [3:0] ST_WALKW  = 4'd8;
   localparam logic [3:0] ST_EMIT   = 4'd9;
   localparam logic [3:0] ST_NFOUND = 4'd10;
   localparam logic [3:0] ST_EDGEW  = 4'd11;
   localparam logic [3:0] ST_EMITW  = 4'd12;

   logic [3:0]    state_ff, state_in;
   logic          order_ff, order_in;
   logic [6:0]    count_ff, count_in;
   logic [CW-1:0] eff_count;
   logic [NW-1:0] src_ff, src_in, dst_ff, dst_in, node_ff, node_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [CW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [MN-1:0] visited_ff, visited_in;
   logic [MN-1:0] row_ff, row_in;
   logic          ebit_ff, ebit_in;
   logic [NW-1:0] eto_ff, eto_in;
   logic [CW-1:0] plen_ff, plen_in;
   logic          out_valid_ff, out_valid_in;
   gps_pkg::rsp_type out_ff, out_in;

   // Adjacency memory ports.
   logic          adj_we;
   logic [NW-1:0] adj_wa, adj_ra;
   logic [MN-1:0] adj_wd, adj_rd;
   // Parent memory ports.
   logic          par_we;
   logic [NW-1:0] par_wa, par_ra, par_wd, par_rd;
   // Worklist memory ports.
   logic          wl_we;
   logic [NW-1:0] wl_wa, wl_ra, wl_wd, wl_rd;
   // Path memory (reversed path) ports.
   logic          pth_we;
   logic [NW-1:0] pth_wa, pth_ra, pth_wd, pth_rd;

   gps_ram #(.Width(MN), .Depth(MN)) u_adj (
      .clock, .wr_en(adj_we), .wr_addr(adj_wa), .wr_data(adj_wd),
      .rd_addr(adj_ra), .rd_data(adj_rd));
   gps_ram #(.Width(NW), .Depth(MN)) u_par (
      .clock, .wr_en(par_we), .wr_addr(par_wa), .wr_data(par_wd),
      .rd_addr(par_ra), .rd_data(par_rd));
   gps_ram #(.Width(NW), .Depth(MN)) u_wl (
      .clock, .wr_en(wl_we), .wr_addr(wl_wa), .wr_data(wl_wd),
      .rd_addr(wl_ra), .rd_data(wl_rd));
   gps_ram #(.Width(NW), .Depth(MN)) u_pth (
      .clock, .wr_en(pth_we), .wr_addr(pth_wa), .wr_data(pth_wd),
      .rd_addr(pth_ra), .rd_data(pth_rd));

   // Saturate the node count to the matrix size.
   assign eff_count = (count_ff > 7'(MN)) ? CW'(MN) : CW'(count_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Main sequencer.
   always_comb begin
      state_in     = state_ff;
      order_in     = order_ff;
      count_in     = count_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      node_in      = node_ff;
      idx_in       = idx_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      clr_in       = clr_ff;
      visited_in   = visited_ff;
      row_in       = row_ff;
      ebit_in      = ebit_ff;
      eto_in       = eto_ff;
      plen_in      = plen_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      adj_we = 1'b0; adj_wa = clr_ff; adj_wd = '0; adj_ra = node_ff;
      par_we = 1'b0; par_wa = idx_ff; par_wd = node_ff; par_ra = node_ff;
      wl_we  = 1'b0; wl_wa = tail_ff[NW-1:0]; wl_wd = idx_ff; wl_ra = '0;
      pth_we = 1'b0; pth_wa = plen_ff[NW-1:0]; pth_wd = node_ff; pth_ra = '0;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (csr_write_enable) begin
         if (csr_index == gps_pkg::CSR_SEARCH_ORDER) begin
            order_in = csr_write_data[0];
         end else begin
            count_in = csr_write_data;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            adj_we = 1'b1;
            adj_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == NW'(MN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               src_in = req_data.from_node;
               dst_in = req_data.to_node;
               if (req_data.operation == gps_pkg::OP_EDGE) begin
                  ebit_in  = req_data.edge_present;
                  eto_in   = req_data.to_node;
                  adj_ra   = req_data.from_node;
                  state_in = ST_EDGE;
               end else if (CW'(req_data.from_node) >= eff_count ||
                            CW'(req_data.to_node) >= eff_count) begin
                  state_in = ST_NFOUND;
               end else begin
                  // Seed the worklist with the source.
                  visited_in = '0;
                  visited_in[req_data.from_node] = 1'b1;
                  wl_we    = 1'b1;
                  wl_wa    = '0;
                  wl_wd    = req_data.from_node;
                  head_in  = '0;
                  tail_in  = CW'(1);
                  state_in = ST_POP;
               end
            end
         end
         ST_EDGE: begin
            // The row is on the read port; keep its address so it stays there.
            adj_ra   = src_ff;
            state_in = ST_EDGEW;
         end
         ST_EDGEW: begin
            adj_we = 1'b1;
            adj_wa = src_ff;
            adj_wd = adj_rd;
            adj_wd[eto_ff] = ebit_ff;
            state_in = ST_IDLE;
         end
         ST_POP: begin
            if (tail_ff > head_ff) begin
               if (order_ff) begin
                  wl_ra   = head_ff[NW-1:0];
                  head_in = head_ff + 1'b1;
               end else begin
                  wl_ra   = NW'(tail_ff - 1'b1);
                  tail_in = tail_ff - 1'b1;
               end
               state_in = ST_POPW;
            end else begin
               state_in = ST_NFOUND;
            end
         end
         ST_POPW: begin
            node_in = wl_rd;
            if (wl_rd == dst_ff) begin
               plen_in  = '0;
               state_in = ST_WALK;
            end else begin
               adj_ra   = wl_rd;
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            row_in   = adj_rd;
            idx_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // One neighbor per cycle, rising index order.
            if (row_ff[idx_ff] && !visited_ff[idx_ff]) begin
               visited_in[idx_ff] = 1'b1;
               par_we = 1'b1;
               if (tail_ff < CW'(MN)) begin
                  wl_we   = 1'b1;
                  tail_in = tail_ff + 1'b1;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (CW'(idx_ff) + 1'b1 >= eff_count) begin
               state_in = ST_POP;
            end
         end
         ST_WALK: begin
            // Record the current node, then fetch its parent.
            pth_we  = 1'b1;
            plen_in = plen_ff + 1'b1;
            if (node_ff == src_ff || plen_ff == CW'(MN - 1)) begin
               state_in = ST_EMITW;
            end else begin
               par_ra   = node_ff;
               state_in = ST_WALKW;
            end
         end
         ST_WALKW: begin
            node_in  = par_rd;
            state_in = ST_WALK;
         end
         ST_EMITW: begin
            // Start reading the last recorded entry, which is the source.
            pth_ra   = NW'(plen_ff - 1'b1);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // pth_rd holds entry plen_ff-1 once the output register is free.
            pth_ra = NW'(plen_ff - 1'b1);
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_in.path_node  = pth_rd;
               out_in.path_found = 1'b1;
               out_in.last       = (plen_ff == CW'(1));
               plen_in = plen_ff - 1'b1;
               pth_ra  = NW'(plen_ff - 2'd2);
               if (plen_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NFOUND: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in      = 1'b1;
               out_in.path_node  = '0;
               out_in.path_found = 1'b0;
               out_in.last       = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         order_ff     <= 1'b0;
         count_ff     <= 7'(MN);
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         visited_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         visited_ff   <= visited_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      node_ff <= node_in;
      idx_ff  <= idx_in;
      row_ff  <= row_in;
      ebit_ff <= ebit_in;
      eto_ff  <= eto_in;
      plen_ff <= plen_in;
      out_ff  <= out_in;
   end

   // The worklist never holds more entries than it has room for.
   assert property (@(posedge clock) disable iff (reset) tail_ff <= CW'(MN))
      else $error("worklist tail overflow");
   // Head never passes tail.
   assert property (@(posedge clock) disable iff (reset) head_ff <= tail_ff)
      else $error("worklist head passed tail");
   // No input is taken during the neighbor scan of a search.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !req_ready)
      else $error("input accepted during scan");
   // A stalled response holds its word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response changed while stalled");

endmodule

// ===== tb/tb_graph_path_search.sv =====
// Testbench for graph_path_search: random and directed edge and find words,
// checked against a path-search predictor held in a small scoreboard class.
// Depends on gps_pkg and the graph_path_search RTL.
module tb_graph_path_search;
   timeunit 1ns;
   timeprecision 1ps;

   // Predicts path words from its own copy of the matrix and registers.
   class path_scoreboard;
      logic [63:0]      adj_rows [64];
      bit               breadth_first;
      int               node_limit;
      gps_pkg::rsp_type pending_words [$];
      int               error_count;
      int               found_count;
      int               miss_count;

      function new();
         foreach (adj_rows[i]) adj_rows[i] = '0;
         breadth_first = 0;
         node_limit = 64;
      endfunction

      function void set_register(logic [0:0] idx, logic [6:0] val);
         if (idx == gps_pkg::CSR_SEARCH_ORDER) breadth_first = val[0];
         else node_limit = (val > 64) ? 64 : val;
      endfunction

      function void push_word(logic [5:0] node, logic found, logic fin);
         gps_pkg::rsp_type w;
         w.path_node = node;
         w.path_found = found;
         w.last = fin;
         pending_words.push_back(w);
      endfunction

      // Notes an accepted input word and queues its expected path words.
      function void note_request(gps_pkg::req_type r);
         bit          seen [64];
         logic [5:0]  parent [64];
         logic [5:0]  work [64];
         logic [5:0]  trail [$];
         int          head, tail, cur;
         logic [5:0]  node;
         if (r.operation == gps_pkg::OP_EDGE) begin
            adj_rows[r.from_node][r.to_node] = r.edge_present;
            return;
         end
         if (r.from_node >= node_limit || r.to_node >= node_limit) begin
            push_word(6'd0, 1'b0, 1'b1);
            miss_count++;
            return;
         end
         foreach (seen[i]) seen[i] = 0;
         head = 0;
         tail = 0;
         work[tail++] = r.from_node;
         seen[r.from_node] = 1;
         while (tail > head) begin
            if (breadth_first) node = work[head++];
            else node = work[--tail];
            if (node == r.to_node) begin
               cur = node;
               trail.push_front(cur[5:0]);
               while (cur != r.from_node && trail.size() < 64) begin
                  cur = parent[cur];
                  trail.push_front(cur[5:0]);
               end
               foreach (trail[k]) push_word(trail[k], 1'b1, k == trail.size() - 1);
               found_count++;
               return;
            end
            for (int i = 0; i < node_limit; i++) begin
               if (adj_rows[node][i] && !seen[i]) begin
                  if (tail < 64) work[tail++] = 6'(i);
                  seen[i] = 1;
                  parent[i] = node;
               end
            end
         end
         push_word(6'd0, 1'b0, 1'b1);
         miss_count++;
      endfunction

      // Compares an accepted path word with the oldest expectation.
      function void check_word(gps_pkg::rsp_type got);
         gps_pkg::rsp_type exp_w;
         if (pending_words.size() == 0) begin
            $error("unexpected word %p", got);
            error_count++;
            return;
         end
         exp_w = pending_words.pop_front();
         if (got.path_node != exp_w.path_node) begin
            $error("path_node expected %0d actual %0d", exp_w.path_node, got.path_node);
            error_count++;
         end
         if (got.path_found != exp_w.path_found) begin
            $error("path_found expected %0d actual %0d", exp_w.path_found, got.path_found);
            error_count++;
         end
         if (got.last != exp_w.last) begin
            $error("last expected %0d actual %0d", exp_w.last, got.last);
            error_count++;
         end
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   gps_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   gps_pkg::rsp_type rsp_data;
   logic             csr_write_enable = 0;
   logic [0:0]       csr_index = '0;
   logic [6:0]       csr_write_data = '0;

   path_scoreboard board = new();
   int  idle_cycles = 0;
   int  long_hold = 0;
   int  burst_left = 0;
   int  req_total = 0;

   graph_path_search u_dut (.*);

   always #5 clock = ~clock;

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 200000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: scoreboard check on acceptance, random stall pattern.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_word(rsp_data);
         if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Drives one word, waiting for acceptance; bursts with random gaps.
   task automatic send_word(gps_pkg::req_type r);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(r);
      req_total++;
      req_valid <= 0;
      // The block is busy for at least this cycle after taking a word.
      @(posedge clock);
   endtask

   task automatic send_fields(logic op, int a, int b, logic bit_val);
      gps_pkg::req_type r;
      r.operation = op;
      r.from_node = 6'(a);
      r.to_node = 6'(b);
      r.edge_present = bit_val;
      send_word(r);
   endtask

   // Waits for all expectations, then lets an edge write settle.
   task automatic drain();
      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(logic [0:0] idx, logic [6:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      board.set_register(idx, val);
      @(posedge clock);
   endtask

   // Random phase: interleaved edge and find words in equal share, mostly within a small node set.
   task automatic random_phase(int words, int span);
      int a, b;
      for (int n = 0; n < words; n++) begin
         a = $urandom_range(0, span - 1);
         b = $urandom_range(0, span - 1);
         case ($urandom_range(0, 9))
            0: send_fields(gps_pkg::OP_FIND, $urandom_range(0, 63), $urandom_range(0, 63),
                           1'($urandom));
            1, 2, 3, 4: send_fields(gps_pkg::OP_EDGE, a, b, $urandom_range(0, 3) != 0);
            5: send_fields(gps_pkg::OP_EDGE, $urandom_range(0, 63), $urandom_range(0, 63),
                           1'($urandom));
            default: send_fields(gps_pkg::OP_FIND, a, b, 1'($urandom));
         endcase
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty graph, same node, extremes, simple chain in both orders.
      send_fields(gps_pkg::OP_FIND, 0, 63, 0);
      send_fields(gps_pkg::OP_FIND, 63, 63, 1);
      send_fields(gps_pkg::OP_FIND, 0, 0, 0);
      send_fields(gps_pkg::OP_EDGE, 0, 1, 1);
      send_fields(gps_pkg::OP_EDGE, 1, 63, 1);
      send_fields(gps_pkg::OP_EDGE, 0, 2, 1);
      send_fields(gps_pkg::OP_EDGE, 2, 63, 1);
      send_fields(gps_pkg::OP_EDGE, 63, 0, 1);
      send_fields(gps_pkg::OP_FIND, 0, 63, 0);
      send_fields(gps_pkg::OP_FIND, 63, 1, 1);
      drain();
      write_register(gps_pkg::CSR_SEARCH_ORDER, 1);
      send_fields(gps_pkg::OP_FIND, 0, 63, 0);
      send_fields(gps_pkg::OP_EDGE, 0, 2, 0);
      send_fields(gps_pkg::OP_FIND, 0, 63, 1);
      drain();
      // Node count limits: edges beyond the count are not followed.
      write_register(gps_pkg::CSR_NODE_COUNT, 2);
      send_fields(gps_pkg::OP_FIND, 0, 1, 0);
      send_fields(gps_pkg::OP_FIND, 0, 63, 0);
      send_fields(gps_pkg::OP_FIND, 2, 0, 0);
      drain();
      write_register(gps_pkg::CSR_NODE_COUNT, 0);
      send_fields(gps_pkg::OP_FIND, 0, 0, 0);
      drain();
      write_register(gps_pkg::CSR_NODE_COUNT, 127);
      send_fields(gps_pkg::OP_FIND, 63, 63, 0);
      drain();
      write_register(gps_pkg::CSR_NODE_COUNT, 1);
      send_fields(gps_pkg::OP_FIND, 0, 0, 0);
      drain();

      // Long chain for the longest path, with the receiver held off past the
      // end of the first search so the output word waits and the input stalls.
      write_register(gps_pkg::CSR_NODE_COUNT, 64);
      write_register(gps_pkg::CSR_SEARCH_ORDER, 0);
      for (int i = 0; i < 63; i++) send_fields(gps_pkg::OP_EDGE, i, i + 1, 1);
      long_hold = 6000;
      for (int i = 0; i < 4; i++) send_fields(gps_pkg::OP_FIND, 0, 63, 1);
      drain();
      write_register(gps_pkg::CSR_SEARCH_ORDER, 1);
      send_fields(gps_pkg::OP_FIND, 0, 63, 0);
      drain();
      // Clear the chain so random graphs start from a sparse matrix.
      for (int i = 0; i < 63; i++) send_fields(gps_pkg::OP_EDGE, i, i + 1, 0);
      drain();

      // Random phases over several register settings.
      write_register(gps_pkg::CSR_NODE_COUNT, 12);
      random_phase(70, 12);
      drain();
      write_register(gps_pkg::CSR_SEARCH_ORDER, 0);
      random_phase(70, 16);
      drain();
      write_register(gps_pkg::CSR_NODE_COUNT, 64);
      random_phase(70, 64);
      drain();
      write_register(gps_pkg::CSR_SEARCH_ORDER, 1);
      write_register(gps_pkg::CSR_NODE_COUNT, 7);
      random_phase(70, 10);
      drain();
      write_register(gps_pkg::CSR_NODE_COUNT, 64);
      random_phase(50, 20);
      drain();

      $display("tb: %0d words sent, %0d paths found, %0d searches without a path.",
               req_total, board.found_count, board.miss_count);
      $display("tb: depth-first and breadth-first, node counts 0 to 127 covered.");
      if (board.error_count == 0 && board.pending_words.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
